// File: hdl/bscd_pkg.sv
package bscd_pkg;

	localparam logic [31:0] SEED_MASK  = 32'hA55A_A55A;
	localparam logic [31:0] LANE_MUL   = 32'h045D_9F3B;
	localparam logic [31:0] GOLDEN_ADD = 32'h9E37_79B9;
	localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME  = 32'd16777619;
	localparam logic [31:0] KEY_RESET  = 32'hC0FF_EE11;
	localparam logic [4:0]  ROT_AMT    = 5'd5;

	// running buffer state; lane_off tracks byte_idx * LANE_MUL
	typedef struct packed {
		logic [31:0] mix;
		logic [31:0] lane_off;
		logic [31:0] byte_idx;
		logic [31:0] hash;
		logic        started;
	} bscd_state_t;

	typedef struct packed {
		logic [7:0]  cipher_byte;
		logic        byte_present;
		logic        buffer_end;
		logic [31:0] end_state;
		logic [31:0] buffer_digest;
	} bscd_result_t;

endpackage

// File: hdl/byte_stream_cipher_with_digest_top.sv
// Byte stream cipher with ciphertext digest.
//
// Input channel (in_valid/in_ready) carries one plaintext byte per word with
// last_byte marking the end of a buffer; empty_buffer closes a buffer with no
// byte. Output channel (out_valid/out_ready) returns one word per input word:
// the cipher byte, and on the closing word the final mixing state and the
// digest (FNV-1a of the ciphertext xor final state).
// cfg_valid/cfg_ready writes cipher_key; the key is picked up when the next
// buffer starts. cfg_ready is always high.
//
// A word accepted at the input passes the input register, then the result
// register, before it shows on the outputs. Throughput is one word per cycle
// while out_ready is high; the whole per-byte update, with one constant
// multiply for FNV, sits between those two registers.
// Reset clears the key to its default and drops both stages; the first word
// after reset starts a new buffer. When out_ready is low the result holds,
// the input register still takes one word if it is empty, then in_ready drops.
module byte_stream_cipher_with_digest_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cipher_key,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  plain_byte,
	input  logic        last_byte,
	input  logic        empty_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  cipher_byte,
	output logic        byte_present,
	output logic        buffer_end,
	output logic [31:0] end_state,
	output logic [31:0] buffer_digest
);

	logic [31:0]            key_q;
	bscd_pkg::bscd_state_t  state_q;
	bscd_pkg::bscd_state_t  state_nxt;
	bscd_pkg::bscd_result_t res_nxt;
	bscd_pkg::bscd_result_t res_q;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   empty_s1;
	logic                   out_valid_q;
	logic                   advance;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= bscd_pkg::KEY_RESET;
		end else if (cfg_valid) begin
			key_q <= cipher_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= plain_byte;
			last_s1  <= last_byte;
			empty_s1 <= empty_buffer;
		end
	end

	bscd_step u_step (
		.cur          (state_q),
		.key          (key_q),
		.plain_byte   (byte_s1),
		.last_byte    (last_s1),
		.empty_buffer (empty_s1),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mix      <= bscd_pkg::KEY_RESET ^ bscd_pkg::SEED_MASK;
			state_q.lane_off <= '0;
			state_q.byte_idx <= '0;
			state_q.hash     <= bscd_pkg::FNV_OFFSET;
			state_q.started  <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign cipher_byte   = res_q.cipher_byte;
	assign byte_present  = res_q.byte_present;
	assign buffer_end    = res_q.buffer_end;
	assign end_state     = res_q.end_state;
	assign buffer_digest = res_q.buffer_digest;

endmodule

// File: hdl/bscd_step.sv
module bscd_step (
	input  bscd_pkg::bscd_state_t  cur,
	input  logic [31:0]            key,
	input  logic [7:0]             plain_byte,
	input  logic                   last_byte,
	input  logic                   empty_buffer,
	output bscd_pkg::bscd_state_t  nxt,
	output bscd_pkg::bscd_result_t res
);

	logic [31:0] mix_e;
	logic [31:0] off_e;
	logic [31:0] idx_e;
	logic [31:0] hash_e;
	logic [31:0] lane;
	logic [7:0]  m_raw;
	logic [7:0]  m_rot;
	logic [7:0]  state_byte;
	logic [7:0]  m;
	logic [31:0] mixed;
	logic [31:0] mix_n;
	logic [31:0] hash_n;
	logic        closing;

	// rearm on the first word of a buffer
	always_comb begin
		if (cur.started) begin
			mix_e  = cur.mix;
			off_e  = cur.lane_off;
			idx_e  = cur.byte_idx;
			hash_e = cur.hash;
		end else begin
			mix_e  = key ^ bscd_pkg::SEED_MASK;
			off_e  = '0;
			idx_e  = '0;
			hash_e = bscd_pkg::FNV_OFFSET;
		end
	end

	always_comb begin
		lane       = mix_e + off_e;
		m_raw      = plain_byte ^ lane[7:0] ^ lane[18:11];
		m_rot      = {m_raw[4:0], m_raw[7:5]};
		state_byte = mix_e[{idx_e[1:0], 3'b000} +: 8];
		m          = m_rot ^ state_byte;
		hash_n     = (hash_e ^ {24'd0, m}) * bscd_pkg::FNV_PRIME;
		mixed      = mix_e ^ {24'd0, m} ^ idx_e;
		mix_n      = {mixed[31-bscd_pkg::ROT_AMT:0], mixed[31:32-bscd_pkg::ROT_AMT]}
			+ bscd_pkg::GOLDEN_ADD;
	end

	always_comb begin
		closing = empty_buffer | last_byte;
		if (empty_buffer) begin
			nxt.mix      = mix_e;
			nxt.lane_off = off_e;
			nxt.byte_idx = idx_e;
			nxt.hash     = hash_e;
		end else begin
			nxt.mix      = mix_n;
			nxt.lane_off = off_e + bscd_pkg::LANE_MUL;
			nxt.byte_idx = idx_e + 32'd1;
			nxt.hash     = hash_n;
		end
		nxt.started = !closing;

		res.cipher_byte  = empty_buffer ? 8'd0 : m;
		res.byte_present = !empty_buffer;
		res.buffer_end   = closing;
		if (closing) begin
			res.end_state     = nxt.mix;
			res.buffer_digest = nxt.hash ^ nxt.mix;
		end else begin
			res.end_state     = '0;
			res.buffer_digest = '0;
		end
	end

endmodule

// File: hdl/bscd_checker.sv
module bscd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  cipher_byte,
	input logic        byte_present,
	input logic        buffer_end,
	input logic [31:0] end_state,
	input logic [31:0] buffer_digest
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(buffer_digest) && $stable(cipher_byte))
		else $error("output word dropped or changed while stalled");

	// a word with no byte must be a buffer close
	a_empty_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_present |-> buffer_end)
		else $error("word carries neither byte nor close");

	a_no_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_present |-> cipher_byte == 8'd0)
		else $error("cipher_byte nonzero without a byte");

	a_mid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !buffer_end |-> end_state == 32'd0 && buffer_digest == 32'd0)
		else $error("state or digest nonzero mid-buffer");

endmodule

bind byte_stream_cipher_with_digest_top bscd_checker u_bscd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.cipher_byte   (cipher_byte),
	.byte_present  (byte_present),
	.buffer_end    (buffer_end),
	.end_state     (end_state),
	.buffer_digest (buffer_digest)
);
